### design/sfr_pkg.sv
// Shared constants, types and helpers for the stream find-and-replace unit.
// No dependencies; compiled first.
package sfr_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 8;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int SHIFT_W     = 4;
	localparam int WORD_W      = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int NUM_SHIFTS  = PATTERN_MAX + 1;
	localparam int ROW_DEPTH   = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

	typedef logic [BYTE_W-1:0] txt_byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIND_PATTERN   = 2'd0,
		REG_FIND_LENGTH    = 2'd1,
		REG_REPLACE_TEXT   = 2'd2,
		REG_REPLACE_LENGTH = 2'd3
	} cfg_reg_t;

	// one output slot of the drain row
	typedef struct packed {
		logic      occ;
		logic      bvalid;
		txt_byte_t data;
	} slot_t;

	typedef struct packed {
		logic load;
		logic pop;
	} row_ctrl_t;

	function automatic txt_byte_t byte_at(input word_t w, input logic [2:0] i);
		byte_at = w[i*BYTE_W +: BYTE_W];
	endfunction

endpackage

### design/sfr_ifs.sv
// Valid/ready channel interfaces: text input, result output, register writes.
// Depends on sfr_pkg.
interface sfr_text_if;
	logic               valid;
	logic               ready;
	sfr_pkg::txt_byte_t text_byte;
	logic               end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface sfr_result_if;
	logic               valid;
	logic               ready;
	sfr_pkg::txt_byte_t out_byte;
	logic               byte_valid;
	logic               last;

	modport source (output valid, out_byte, byte_valid, last, input ready);
	modport sink   (input valid, out_byte, byte_valid, last, output ready);
endinterface

interface sfr_cfg_if;
	logic              valid;
	logic              ready;
	sfr_pkg::cfg_reg_t index;
	sfr_pkg::word_t    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### design/stream_find_and_replace_unit.sv
// Top level of the stream find-and-replace unit: matcher row, drain row, result register.
// Depends on sfr_pkg, sfr_ifs, sfr_match_cell, sfr_out_cell.
//
//  channel  dir  payload                          transaction
//  text     in   text_byte[7:0], end_of_text      valid & ready
//  result   out  out_byte[7:0], byte_valid, last  valid & ready
//  cfg      in   index[1:0], data[63:0]           valid & ready (ready tied high)
//
// Flow: while the result port is not held, a byte that yields at most one result goes
//   in every cycle and the drain row hands one result per cycle to the result register;
//   a byte yielding m results (m up to 8) holds the text channel until the row is empty.
// Path: a byte's results go from the drain row through the result register to the port.
// Reset: arst_n clears the partial match, the row and the result register;
//   registers return to pattern 0, length 1, no replacement.
// Stalls: a held result stalls the row, and the text channel too while the row holds
//   bytes; a byte is taken while the result register still waits if the row is empty.
module stream_find_and_replace_unit (
	input  logic         clk,
	input  logic         arst_n,
	sfr_text_if.sink     text,
	sfr_result_if.source result,
	sfr_cfg_if.sink      cfg
);
	import sfr_pkg::*;

	// ---------------- configuration registers ----------------
	word_t pat_q;
	len_t  flen_q;
	word_t rtxt_q;
	len_t  rlen_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			flen_q <= len_t'(1);
			rtxt_q <= '0;
			rlen_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FIND_PATTERN:   pat_q  <= cfg.data;
				REG_FIND_LENGTH:    flen_q <= cfg.data[LEN_W-1:0];
				REG_REPLACE_TEXT:   rtxt_q <= cfg.data;
				REG_REPLACE_LENGTH: rlen_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective lengths: pattern 1..PATTERN_MAX, replacement 0..REPLACE_MAX
	len_t plen;
	len_t rlen;
	always_comb begin
		if (flen_q == '0)
			plen = len_t'(1);
		else if (flen_q > len_t'(PATTERN_MAX))
			plen = len_t'(PATTERN_MAX);
		else
			plen = flen_q;
		rlen = (rlen_q > len_t'(REPLACE_MAX)) ? len_t'(REPLACE_MAX) : rlen_q;
	end

	// ---------------- partial match state ----------------
	len_t matched_q;
	len_t k;
	len_t n;

	// a stale count (pattern shortened mid-string) is read as plen - 1
	assign k = (matched_q >= plen) ? (plen - len_t'(1)) : matched_q;
	assign n = k + len_t'(1);

	// ---------------- matcher row ----------------
	// Cell s tests whether the held prefix plus the new byte, shifted by s,
	// still lines up with the pattern start. The first hit down the row wins.
	logic [NUM_SHIFTS:0]   found;
	logic [NUM_SHIFTS-1:0] sel;

	assign found[0] = 1'b0;

	for (genvar j = 0; j < NUM_SHIFTS; j++) begin : g_match
		sfr_match_cell u_cell (
			.shift     (SHIFT_W'(j)),
			.k         (k),
			.text_byte (text.text_byte),
			.pattern   (pat_q),
			.found_in  (found[j]),
			.found_out (found[j+1]),
			.sel       (sel[j])
		);
	end

	len_t s;
	always_comb begin
		s = '0;
		for (int j = 0; j < NUM_SHIFTS; j++)
			if (sel[j]) s = s | len_t'(j);
	end

	// full match only when nothing was shifted out and the prefix reached plen
	logic full_match;
	assign full_match = (s == '0) && (n == plen);

	// ---------------- burst build ----------------
	// A byte produces either the replacement, or the bytes shifted out
	// (all n held bytes at end of text). Held bytes below k are pattern bytes.
	len_t  burst_len;
	slot_t burst [ROW_DEPTH];
	len_t  matched_nxt;

	always_comb begin
		if (full_match)
			burst_len = rlen;
		else if (text.end_of_text)
			burst_len = n;
		else
			burst_len = s;

		for (int i = 0; i < ROW_DEPTH; i++) begin
			burst[i].occ    = (len_t'(i) < burst_len);
			burst[i].bvalid = 1'b1;
			if (full_match)
				burst[i].data = byte_at(rtxt_q, 3'(i));
			else if (len_t'(i) < k)
				burst[i].data = byte_at(pat_q, 3'(i));
			else
				burst[i].data = text.text_byte;
		end

		// end of text with nothing to send: empty terminator
		if ((burst_len == '0) && text.end_of_text) begin
			burst[0].occ    = 1'b1;
			burst[0].bvalid = 1'b0;
			burst[0].data   = '0;
		end

		matched_nxt = (full_match || text.end_of_text) ? len_t'(0) : (n - s);
	end

	// ---------------- drain row ----------------
	slot_t     row [ROW_DEPTH];
	slot_t     row_next [ROW_DEPTH];
	row_ctrl_t row_ctrl;
	logic      end_q;
	logic      res_valid_q;
	logic      pop;
	logic      accept;

	assign pop        = row[0].occ && (!res_valid_q || result.ready);
	// room when empty, or when the last slot leaves this cycle
	assign text.ready = !row[0].occ || (pop && !row[1].occ);
	assign accept     = text.valid && text.ready;

	assign row_ctrl = '{load: accept, pop: pop};

	for (genvar i = 0; i < ROW_DEPTH; i++) begin : g_row
		if (i == ROW_DEPTH - 1) begin : g_top
			assign row_next[i] = '0;
		end else begin : g_mid
			assign row_next[i] = row[i+1];
		end

		sfr_out_cell u_slot (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (row_ctrl),
			.load_slot (burst[i]),
			.next_slot (row_next[i]),
			.slot      (row[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= '0;
			end_q     <= 1'b0;
		end else if (accept) begin
			matched_q <= matched_nxt;
			end_q     <= text.end_of_text;
		end
	end

	// ---------------- result register ----------------
	txt_byte_t res_byte_q;
	logic      res_bvalid_q;
	logic      res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// last goes on the final slot of an end-of-text burst
	always_ff @(posedge clk) begin
		if (pop) begin
			res_byte_q   <= row[0].data;
			res_bvalid_q <= row[0].bvalid;
			res_last_q   <= end_q && !row[1].occ;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.out_byte   = res_byte_q;
	assign result.byte_valid = res_bvalid_q;
	assign result.last       = res_last_q;

endmodule

### design/sfr_match_cell.sv
// One shift candidate of the matcher row; passes the "found" flag down the row.
// Depends on sfr_pkg.
module sfr_match_cell (
	input  logic [sfr_pkg::SHIFT_W-1:0] shift,
	input  sfr_pkg::len_t               k,
	input  sfr_pkg::txt_byte_t          text_byte,
	input  sfr_pkg::word_t              pattern,
	input  logic                        found_in,
	output logic                        found_out,
	output logic                        sel
);
	import sfr_pkg::*;

	logic             border;
	logic             here_ok;
	logic [LEN_W:0]   pos;
	logic [LEN_W-1:0] off;

	// kept bytes from this shift on must equal the pattern start
	always_comb begin
		border = 1'b1;
		pos    = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pos = {1'b0, shift} + (LEN_W+1)'(i);
			if (pos < {1'b0, k}) begin
				if (byte_at(pattern, pos[2:0]) != byte_at(pattern, 3'(i)))
					border = 1'b0;
			end
		end
	end

	assign off = k - shift;

	always_comb begin
		here_ok = (shift <= k) && border && (text_byte == byte_at(pattern, off[2:0]));
		// shift past the new byte always fits: everything goes out
		if ({1'b0, shift} == ({1'b0, k} + (LEN_W+1)'(1)))
			here_ok = 1'b1;
	end

	assign found_out = found_in | here_ok;
	assign sel       = here_ok & ~found_in;

endmodule

### design/sfr_out_cell.sv
// One slot of the drain row; loads a burst byte or takes its upper neighbor.
// Depends on sfr_pkg.
module sfr_out_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sfr_pkg::row_ctrl_t ctrl,
	input  sfr_pkg::slot_t     load_slot,
	input  sfr_pkg::slot_t     next_slot,
	output sfr_pkg::slot_t     slot
);
	import sfr_pkg::*;

	logic      occ_q;
	logic      bvalid_q;
	txt_byte_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.load) begin
			occ_q <= load_slot.occ;
		end else if (ctrl.pop) begin
			occ_q <= next_slot.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bvalid_q <= load_slot.bvalid;
			data_q   <= load_slot.data;
		end else if (ctrl.pop) begin
			bvalid_q <= next_slot.bvalid;
			data_q   <= next_slot.data;
		end
	end

	assign slot = '{occ: occ_q, bvalid: bvalid_q, data: data_q};

endmodule
